@@ sv/sbts_pkg.sv @@
// Shared types and constants for the subcarrier bin threshold slicer.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package sbts_pkg;

  // Default geometry, used as the defaults of the top level's parameters
  localparam int MAX_SUBCARRIERS = 4;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COUNT_WIDTH     = 32;

  // Fixed field widths
  localparam int MAG_W       = 16;
  localparam int BITS_W      = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_SUB_W   = 3;
  localparam int SUB_REGS    = 4;

  localparam logic [MAG_W-1:0]      MAG_MAX       = 16'hFFFF;
  localparam logic [CFG_DATA_W-1:0] SYM_LEN_RESET = 16'd64;

  // Configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SYM_LEN    = 3'd1,
    REG_NUM_SUB    = 3'd2,
    REG_PICK_POS_0 = 3'd3,
    REG_PICK_POS_1 = 3'd4,
    REG_PICK_POS_2 = 3'd5,
    REG_PICK_POS_3 = 3'd6
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_I,
    ST_SQ_Q,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic square_i;
    logic square_q;
    logic sum;
    logic root_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic root_last;
    logic out_busy;
  } dp_status_t;

endpackage

@@ sv/sbts_ctrl.sv @@
// Sequencing controller for the slicer: squares, sum, root loop, commit.
// Depends on sbts_pkg (state and command/status types).
module sbts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sbts_pkg::dp_status_t   status,
  output sbts_pkg::dp_cmd_t      cmd
);

  sbts_pkg::state_t state;
  sbts_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbts_pkg::ST_IDLE: begin
        if (in_valid) state_next = sbts_pkg::ST_SQ_I;
      end
      sbts_pkg::ST_SQ_I: state_next = sbts_pkg::ST_SQ_Q;
      sbts_pkg::ST_SQ_Q: state_next = sbts_pkg::ST_SUM;
      sbts_pkg::ST_SUM:  state_next = sbts_pkg::ST_ROOT;
      sbts_pkg::ST_ROOT: begin
        if (status.root_last) state_next = sbts_pkg::ST_DONE;
      end
      sbts_pkg::ST_DONE: begin
        if (!status.out_busy) state_next = sbts_pkg::ST_IDLE;
      end
      default: state_next = sbts_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      sbts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sbts_pkg::ST_SQ_I: cmd.square_i  = 1'b1;
      sbts_pkg::ST_SQ_Q: cmd.square_q  = 1'b1;
      sbts_pkg::ST_SUM:  cmd.sum       = 1'b1;
      sbts_pkg::ST_ROOT: cmd.root_step = 1'b1;
      sbts_pkg::ST_DONE: cmd.commit    = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/sbts_dp.sv @@
// Datapath for the slicer: config registers, squarer, bit-serial root,
// sample counter, per-subcarrier offsets and the output register.
// Depends on sbts_pkg (widths, register map, command/status types).
module sbts_dp #(
  parameter int SAMPLE_WIDTH    = sbts_pkg::SAMPLE_WIDTH,
  parameter int COUNT_WIDTH     = sbts_pkg::COUNT_WIDTH,
  parameter int MAX_SUBCARRIERS = sbts_pkg::MAX_SUBCARRIERS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [sbts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sbts_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_q,
  input  sbts_pkg::dp_cmd_t                    cmd,
  output sbts_pkg::dp_status_t                 status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [sbts_pkg::MAG_W-1:0]           magnitude,
  output logic [sbts_pkg::BITS_W-1:0]          bit_valid_mask,
  output logic [sbts_pkg::BITS_W-1:0]          bit_values
);

  localparam int RW     = SAMPLE_WIDTH;
  localparam int SQ_W   = 2 * SAMPLE_WIDTH;
  localparam int REM_W  = RW + 3;
  localparam int ITER_W = $clog2(RW);
  localparam int RWE    = (RW > sbts_pkg::MAG_W) ? RW : sbts_pkg::MAG_W;

  // Configuration registers
  logic [sbts_pkg::CFG_DATA_W-1:0] threshold;
  logic [sbts_pkg::CFG_DATA_W-1:0] sym_len;
  logic [sbts_pkg::NUM_SUB_W-1:0]  num_subcarriers;
  logic [sbts_pkg::CFG_DATA_W-1:0] pick_pos [sbts_pkg::SUB_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      sym_len         <= sbts_pkg::SYM_LEN_RESET;
      num_subcarriers <= '0;
      for (int k = 0; k < sbts_pkg::SUB_REGS; k++) pick_pos[k] <= '0;
    end else if (cfg_wr_en) begin
      unique case (sbts_pkg::cfg_reg_t'(cfg_index))
        sbts_pkg::REG_THRESHOLD:  threshold       <= cfg_data;
        sbts_pkg::REG_SYM_LEN:    sym_len         <= cfg_data;
        sbts_pkg::REG_NUM_SUB:    num_subcarriers <= cfg_data[sbts_pkg::NUM_SUB_W-1:0];
        sbts_pkg::REG_PICK_POS_0: pick_pos[0]     <= cfg_data;
        sbts_pkg::REG_PICK_POS_1: pick_pos[1]     <= cfg_data;
        sbts_pkg::REG_PICK_POS_2: pick_pos[2]     <= cfg_data;
        sbts_pkg::REG_PICK_POS_3: pick_pos[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Absolute values captured with the request
  logic [RW-1:0] abs_i;
  logic [RW-1:0] abs_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      abs_i <= sample_i[RW-1] ? $unsigned(-sample_i) : $unsigned(sample_i);
      abs_q <= sample_q[RW-1] ? $unsigned(-sample_q) : $unsigned(sample_q);
    end
  end

  // Shared squarer, product registered before the add
  logic [RW-1:0]   mul_a;
  logic [SQ_W-1:0] product;
  logic [SQ_W-1:0] prod_reg;
  logic [SQ_W-1:0] radicand;

  assign mul_a   = cmd.square_q ? abs_q : abs_i;
  assign product = SQ_W'(mul_a) * SQ_W'(mul_a);

  // Bit-serial restoring square root, one result bit per cycle
  logic [REM_W-1:0]  rem;
  logic [RW-1:0]     root;
  logic [ITER_W-1:0] iter;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              trial_ok;

  assign rem_shift = {rem[REM_W-3:0], radicand[SQ_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign trial_ok  = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (cmd.square_i || cmd.square_q) prod_reg <= product;
    if (cmd.square_q) radicand <= prod_reg;
    if (cmd.sum) begin
      radicand <= radicand + prod_reg;
      rem      <= '0;
      root     <= '0;
      iter     <= '0;
    end
    if (cmd.root_step) begin
      rem      <= trial_ok ? (rem_shift - trial) : rem_shift;
      root     <= {root[RW-2:0], trial_ok};
      radicand <= radicand << 2;
      iter     <= iter + ITER_W'(1);
    end
  end

  assign status.root_last = (iter == ITER_W'(RW - 1));
  assign status.out_busy  = out_valid && !out_ready;

  // Saturate the root to the magnitude field
  logic [RWE-1:0]            root_ext;
  logic [sbts_pkg::MAG_W-1:0] mag_sat;
  logic                       mag_ge;

  assign root_ext = RWE'(root);
  assign mag_sat  = (root_ext > RWE'(sbts_pkg::MAG_MAX)) ? sbts_pkg::MAG_MAX
                                                         : root_ext[sbts_pkg::MAG_W-1:0];
  assign mag_ge   = mag_sat >= threshold;

  // Sample counter, per-subcarrier offsets and hit detection
  logic [COUNT_WIDTH-1:0]     sample_counter;
  logic [COUNT_WIDTH-1:0]     period_offset [MAX_SUBCARRIERS];
  logic [MAX_SUBCARRIERS-1:0] hit_now;
  logic [MAX_SUBCARRIERS-1:0] hits;

  for (genvar j = 0; j < MAX_SUBCARRIERS; j++) begin : g_sub
    logic [sbts_pkg::CFG_DATA_W-1:0] idx;
    logic                            active;
    if (j < sbts_pkg::SUB_REGS) begin : g_reg
      assign idx = pick_pos[j];
    end else begin : g_zero
      assign idx = '0;
    end
    assign active     = 4'(j) < {1'b0, num_subcarriers};
    assign hit_now[j] = active &&
                        (sample_counter == (COUNT_WIDTH'(idx) + period_offset[j]));

    always_ff @(posedge clk) begin
      if (rst) begin
        period_offset[j] <= '0;
      end else if (cmd.commit && hits[j]) begin
        period_offset[j] <= period_offset[j] + COUNT_WIDTH'(sym_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square_i) hits <= hit_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else if (cmd.commit) begin
      sample_counter <= sample_counter + COUNT_WIDTH'(1);
    end
  end

  // Output register
  logic [MAX_SUBCARRIERS-1:0] out_mask;
  logic [MAX_SUBCARRIERS-1:0] out_vals;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      magnitude <= mag_sat;
      out_mask  <= hits;
      out_vals  <= hits & {MAX_SUBCARRIERS{mag_ge}};
    end
  end

  // Map subcarrier bits onto the fixed-width result fields
  for (genvar k = 0; k < sbts_pkg::BITS_W; k++) begin : g_bits
    if (k < MAX_SUBCARRIERS) begin : g_on
      assign bit_valid_mask[k] = out_mask[k];
      assign bit_values[k]     = out_vals[k];
    end else begin : g_off
      assign bit_valid_mask[k] = 1'b0;
      assign bit_values[k]     = 1'b0;
    end
  end

endmodule

@@ sv/subcarrier_bin_threshold_slicer.sv @@
// Subcarrier bin threshold slicer: magnitude of each I/Q request, plus a
// threshold bit for each watched subcarrier position.
// Input channel: in_valid/in_ready with sample_i, sample_q. One result per
// request on out_valid/out_ready: magnitude, bit_valid_mask, bit_values.
// Configuration: cfg_wr_en, cfg_index, cfg_data; 0 threshold, 1 symbol length,
// 2 num_subcarriers, 3..6 pick positions 0..3. Write only while the block is idle.
// An accepted request passes the squares of I and Q on the shared squarer,
// one add, and the square root, which resolves one result bit per cycle;
// the result is then committed to the output register. A new request is
// taken only after the previous one has been committed.
// A finished result sits in the output register while the next request is
// taken and worked on; if the receiver still stalls when the next result is
// ready, the block holds that result internally and takes no new request.
// Reset (rst, synchronous): registers to threshold 0, symbol length 64,
// num_subcarriers 0, pick positions 0; sample counter and offsets to zero;
// output empty. No clearing pass is needed.
// Depends on sbts_pkg, sbts_ctrl, sbts_dp.
module subcarrier_bin_threshold_slicer #(
  parameter int MAX_SUBCARRIERS = sbts_pkg::MAX_SUBCARRIERS,
  parameter int SAMPLE_WIDTH    = sbts_pkg::SAMPLE_WIDTH,
  parameter int COUNT_WIDTH     = sbts_pkg::COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sbts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_q,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sbts_pkg::MAG_W-1:0]       magnitude,
  output logic [sbts_pkg::BITS_W-1:0]      bit_valid_mask,
  output logic [sbts_pkg::BITS_W-1:0]      bit_values
);

  sbts_pkg::dp_cmd_t    cmd;
  sbts_pkg::dp_status_t status;

  // Sequencer
  sbts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  sbts_dp #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COUNT_WIDTH     (COUNT_WIDTH),
    .MAX_SUBCARRIERS (MAX_SUBCARRIERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_i       (sample_i),
    .sample_q       (sample_q),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .magnitude      (magnitude),
    .bit_valid_mask (bit_valid_mask),
    .bit_values     (bit_values)
  );

endmodule

@@ sv/sbts_checker.sv @@
// Port-level checks for the slicer, bound onto the top level.
// Depends on sbts_pkg and subcarrier_bin_threshold_slicer.
module sbts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sbts_pkg::MAG_W-1:0]  magnitude,
  input logic [sbts_pkg::BITS_W-1:0] bit_valid_mask,
  input logic [sbts_pkg::BITS_W-1:0] bit_values
);

  // One request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  // A decision bit only where its subcarrier fired
  a_bits_in_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((bit_values & ~bit_valid_mask) == '0))
    else $error("bit_values set outside bit_valid_mask");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(magnitude) && $stable(bit_valid_mask) && $stable(bit_values)))
    else $error("stalled result changed");

endmodule

bind subcarrier_bin_threshold_slicer sbts_checker u_sbts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .magnitude      (magnitude),
  .bit_valid_mask (bit_valid_mask),
  .bit_values     (bit_values)
);
